// ===== hdl/lobm_pkg.sv =====
`default_nettype none
package lobm_pkg;

    localparam int BOOK_DEPTH_DEF = 256;
    localparam int PRICE_BITS_DEF = 16;
    localparam int IDENT_BITS     = 32;
    localparam int AMOUNT_BITS    = 24;
    localparam int ARRIVAL_BITS   = 32;

    localparam logic [1:0] CMD_LIMIT  = 2'd0;
    localparam logic [1:0] CMD_MARKET = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic [1:0] STATUS_FILLED   = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/limit_order_book_matcher.sv =====
// Channel  | handshake              | payload
// request  | in_valid / in_stall    | cmd, side, order_ident, limit_price, amount
// result   | out_valid / out_stall  | echo_ident, status, first_fill_price,
//          |                        | filled_amount, rest_dropped
//
// One request at a time. Each pass over the book memory reads one slot a
// cycle. A cancel takes one pass. An order takes one pass and one update step
// per fill, plus one more pass and update step unless a fill used up its amount;
// zero amounts and bad codes skip passes. The result loads in the finish state
// after the last pass or update, or after acceptance; out_stall holds a result,
// and delays the next. Reset empties the book through the slot valid flags.
`default_nettype none
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF,
    parameter int PRICE_BITS = lobm_pkg::PRICE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        cmd,
    input  wire logic                              side,
    input  wire logic [lobm_pkg::IDENT_BITS-1:0]   order_ident,
    input  wire logic [PRICE_BITS-1:0]             limit_price,
    input  wire logic [lobm_pkg::AMOUNT_BITS-1:0]  amount,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [lobm_pkg::IDENT_BITS-1:0]        echo_ident,
    output logic [1:0]                             status,
    output logic [PRICE_BITS-1:0]                  first_fill_price,
    output logic [lobm_pkg::AMOUNT_BITS-1:0]       filled_amount,
    output logic                                   rest_dropped
);
    import lobm_pkg::*;

    localparam int AW = $clog2(BOOK_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    typedef struct packed {
        logic                    side;
        logic [PRICE_BITS-1:0]   price;
        logic [IDENT_BITS-1:0]   ident;
        logic [AMOUNT_BITS-1:0]  amount;
        logic [ARRIVAL_BITS-1:0] arrival;
    } slot_t;

    slot_t slot_mem [BOOK_DEPTH];
    slot_t rd_data_reg;

    logic [1:0]              state_reg, state_next;
    logic [AW:0]             cnt_reg, cnt_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [AW-1:0]           rd_idx_reg, rd_idx_next;
    logic [BOOK_DEPTH-1:0]   valid_reg, valid_next;
    logic [ARRIVAL_BITS-1:0] counter_reg, counter_next;
    logic                    best_found_reg, best_found_next;
    logic                    free_found_reg, free_found_next;
    logic                    out_valid_reg, out_valid_next;

    logic [1:0]              cmd_reg, cmd_next;
    logic                    side_reg, side_next;
    logic [IDENT_BITS-1:0]   ident_reg, ident_next;
    logic [PRICE_BITS-1:0]   price_reg, price_next;
    logic [AMOUNT_BITS-1:0]  rem_reg, rem_next;
    logic [AMOUNT_BITS-1:0]  filled_reg, filled_next;
    logic [PRICE_BITS-1:0]   first_reg, first_next;
    logic                    matched_reg, matched_next;
    logic                    rested_reg, rested_next;
    logic                    dropped_reg, dropped_next;
    logic [AW-1:0]           best_idx_reg, best_idx_next;
    slot_t                   best_reg, best_next;
    logic [ARRIVAL_BITS-1:0] best_age_reg, best_age_next;
    logic [AW-1:0]           free_idx_reg, free_idx_next;

    logic [IDENT_BITS-1:0]   echo_reg, echo_next;
    logic [1:0]              status_reg, status_next;
    logic [PRICE_BITS-1:0]   ofirst_reg, ofirst_next;
    logic [AMOUNT_BITS-1:0]  ofilled_reg, ofilled_next;
    logic                    odropped_reg, odropped_next;

    logic                    mem_re, mem_we;
    logic [AW-1:0]           wr_addr;
    slot_t                   wr_data;
    logic                    cur_valid, better, eligible;
    logic [ARRIVAL_BITS-1:0] cur_age;
    logic [AMOUNT_BITS-1:0]  fill;

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign echo_ident       = echo_reg;
    assign status           = status_reg;
    assign first_fill_price = ofirst_reg;
    assign filled_amount    = ofilled_reg;
    assign rest_dropped     = odropped_reg;

    assign cur_valid = valid_reg[rd_idx_reg];
    assign cur_age   = counter_reg - rd_data_reg.arrival;
    assign better    = !best_found_reg
                    || ((rd_data_reg.price == best_reg.price) ? (cur_age > best_age_reg)
                    : ((side_reg == SIDE_BUY) ? (rd_data_reg.price < best_reg.price)
                                              : (rd_data_reg.price > best_reg.price)));
    assign eligible  = best_found_reg
                    && ((cmd_reg == CMD_MARKET)
                    || ((side_reg == SIDE_BUY) ? (best_reg.price <= price_reg)
                                               : (best_reg.price >= price_reg)));
    assign fill      = (rem_reg < best_reg.amount) ? rem_reg : best_reg.amount;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = cnt_reg[AW-1:0];
        valid_next      = valid_reg;
        counter_next    = counter_reg;
        best_found_next = best_found_reg;
        free_found_next = free_found_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cmd_next        = cmd_reg;
        side_next       = side_reg;
        ident_next      = ident_reg;
        price_next      = price_reg;
        rem_next        = rem_reg;
        filled_next     = filled_reg;
        first_next      = first_reg;
        matched_next    = matched_reg;
        rested_next     = rested_reg;
        dropped_next    = dropped_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        best_age_next   = best_age_reg;
        free_idx_next   = free_idx_reg;
        echo_next       = echo_reg;
        status_next     = status_reg;
        ofirst_next     = ofirst_reg;
        ofilled_next    = ofilled_reg;
        odropped_next   = odropped_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        wr_addr         = best_idx_reg;
        wr_data         = best_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = cmd;
                    side_next       = side;
                    ident_next      = order_ident;
                    price_next      = limit_price;
                    rem_next        = amount;
                    filled_next     = '0;
                    first_next      = '0;
                    matched_next    = 1'b0;
                    rested_next     = 1'b0;
                    dropped_next    = 1'b0;
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    free_found_next = 1'b0;
                    if ((cmd == CMD_CANCEL)
                        || (((cmd == CMD_LIMIT) || (cmd == CMD_MARKET)) && (amount != '0)))
                        state_next = S_SCAN;
                    else
                        state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != (AW+1)'(BOOK_DEPTH))
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (cmd_reg == CMD_CANCEL)
                    begin
                        if (cur_valid && (rd_data_reg.ident == ident_reg))
                            valid_next[rd_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        if (!cur_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = rd_idx_reg;
                        end
                        if (cur_valid && (rd_data_reg.side != side_reg) && better)
                        begin
                            best_found_next = 1'b1;
                            best_idx_next   = rd_idx_reg;
                            best_next       = rd_data_reg;
                            best_age_next   = cur_age;
                        end
                    end
                end
                if ((cnt_reg == (AW+1)'(BOOK_DEPTH)) && !rd_vld_reg)
                    state_next = (cmd_reg == CMD_CANCEL) ? S_FINISH : S_DECIDE;
            end
            S_DECIDE:
            begin
                if (eligible)
                begin
                    mem_we         = 1'b1;
                    wr_addr        = best_idx_reg;
                    wr_data        = best_reg;
                    wr_data.amount = best_reg.amount - fill;
                    if (best_reg.amount == fill)
                        valid_next[best_idx_reg] = 1'b0;
                    if (!matched_reg)
                        first_next = best_reg.price;
                    matched_next = 1'b1;
                    rem_next     = rem_reg - fill;
                    filled_next  = filled_reg + fill;
                    if (rem_reg == fill)
                        state_next = S_FINISH;
                    else
                    begin
                        cnt_next        = '0;
                        best_found_next = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
                else
                begin
                    if (cmd_reg == CMD_LIMIT)
                    begin
                        if (free_found_reg)
                        begin
                            mem_we                   = 1'b1;
                            wr_addr                  = free_idx_reg;
                            wr_data.side             = side_reg;
                            wr_data.price            = price_reg;
                            wr_data.ident            = ident_reg;
                            wr_data.amount           = rem_reg;
                            wr_data.arrival          = counter_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            counter_next             = counter_reg + 1'b1;
                            rested_next              = 1'b1;
                        end
                        else
                            dropped_next = 1'b1;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    echo_next      = ident_reg;
                    ofirst_next    = first_reg;
                    ofilled_next   = filled_reg;
                    odropped_next  = dropped_reg;
                    if (cmd_reg == CMD_CANCEL)
                        status_next = STATUS_ACCEPTED;
                    else if (matched_reg)
                        status_next = STATUS_FILLED;
                    else if (rested_reg)
                        status_next = STATUS_ACCEPTED;
                    else
                        status_next = STATUS_REJECTED;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= slot_mem[cnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            valid_reg      <= '0;
            counter_reg    <= '0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_vld_reg     <= rd_vld_next;
            valid_reg      <= valid_next;
            counter_reg    <= counter_next;
            best_found_reg <= best_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        cmd_reg      <= cmd_next;
        side_reg     <= side_next;
        ident_reg    <= ident_next;
        price_reg    <= price_next;
        rem_reg      <= rem_next;
        filled_reg   <= filled_next;
        first_reg    <= first_next;
        matched_reg  <= matched_next;
        rested_reg   <= rested_next;
        dropped_reg  <= dropped_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        free_idx_reg <= free_idx_next;
        echo_reg     <= echo_next;
        status_reg   <= status_next;
        ofirst_reg   <= ofirst_next;
        ofilled_reg  <= ofilled_next;
        odropped_reg <= odropped_next;
    end

    a_fill_hits_live_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && eligible) |-> valid_reg[best_idx_reg])
        else $error("fill targets an empty slot");

    a_filled_has_amount: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_FILLED) |-> (filled_amount != '0))
        else $error("filled result with zero amount");

    a_dropped_not_rested: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rest_dropped) |-> (status != STATUS_ACCEPTED))
        else $error("dropped remainder reported as rested");

    a_rest_uses_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && !eligible && cmd_reg == CMD_LIMIT && free_found_reg)
        |-> !valid_reg[free_idx_reg])
        else $error("rest into occupied slot");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import lobm_pkg::*;

    localparam int DEPTH = 256;
    localparam int CYCLE_LIMIT = 5000000;
    localparam logic [1:0] CMD_BAD = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_LIMIT;
    logic        side = SIDE_BUY;
    logic [31:0] order_ident = '0;
    logic [15:0] limit_price = '0;
    logic [23:0] amount = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] echo_ident;
    logic [1:0]  status;
    logic [15:0] first_fill_price;
    logic [23:0] filled_amount;
    logic        rest_dropped;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        side;
        logic [31:0] ident;
        logic [15:0] price;
        logic [23:0] amount;
    } order_req_t;

    typedef struct packed {
        logic [31:0] ident;
        logic [1:0]  status;
        logic [15:0] price;
        logic [23:0] filled;
        logic        dropped;
    } fill_report_t;

    order_req_t   pending_q[$];
    fill_report_t awaited_q[$];
    logic         hold_sender = 1'b0;
    logic         in_taken = 1'b0;
    int           errors = 0;
    int           sent = 0;
    int           reports_seen = 0;
    int           fills_seen = 0;
    int           drops_seen = 0;
    int           cycles = 0;
    int           gap_left = 0;
    int           stall_left = 0;

    logic        bk_valid[DEPTH];
    logic        bk_side[DEPTH];
    logic [15:0] bk_price[DEPTH];
    logic [31:0] bk_ident[DEPTH];
    logic [23:0] bk_amount[DEPTH];
    logic [31:0] bk_arrival[DEPTH];
    logic [31:0] arrivals;

    limit_order_book_matcher dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .side(side), .order_ident(order_ident),
        .limit_price(limit_price), .amount(amount), .out_valid(out_valid),
        .out_stall(out_stall), .echo_ident(echo_ident), .status(status),
        .first_fill_price(first_fill_price), .filled_amount(filled_amount),
        .rest_dropped(rest_dropped)
    );

    always #4 clk = ~clk;

    function automatic void queue_req(order_req_t r);
        pending_q = {pending_q, r};
    endfunction

    function automatic void await_report(fill_report_t e);
        awaited_q = {awaited_q, e};
    endfunction

    function automatic int best_resting(logic rs);
        int best;
        best = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!bk_valid[i] || bk_side[i] != rs)
                continue;
            if (best < 0)
                best = i;
            else if (bk_price[i] == bk_price[best])
            begin
                if (arrivals - bk_arrival[i] > arrivals - bk_arrival[best])
                    best = i;
            end
            else if (rs == SIDE_SELL ? bk_price[i] < bk_price[best]
                                     : bk_price[i] > bk_price[best])
                best = i;
        end
        return best;
    endfunction

    function automatic fill_report_t match_order(order_req_t r);
        fill_report_t res;
        logic [23:0] left, fill;
        int b, f;
        bit matched;
        res = '{ident: r.ident, status: STATUS_REJECTED, price: '0, filled: '0,
                dropped: 1'b0};
        left = r.amount;
        matched = 0;
        if (r.cmd == CMD_CANCEL)
        begin
            for (int i = 0; i < DEPTH; i++)
                if (bk_valid[i] && bk_ident[i] == r.ident)
                    bk_valid[i] = 1'b0;
            res.status = STATUS_ACCEPTED;
        end
        else if (r.cmd == CMD_LIMIT || r.cmd == CMD_MARKET)
        begin
            while (left > 0)
            begin
                b = best_resting(~r.side);
                if (b < 0)
                    break;
                if (r.cmd == CMD_LIMIT && (r.side == SIDE_BUY ? bk_price[b] > r.price
                                                             : bk_price[b] < r.price))
                    break;
                fill = left < bk_amount[b] ? left : bk_amount[b];
                if (!matched)
                    res.price = bk_price[b];
                matched = 1;
                bk_amount[b] -= fill;
                left -= fill;
                res.filled += fill;
                if (bk_amount[b] == 0)
                    bk_valid[b] = 1'b0;
            end
            res.status = matched ? STATUS_FILLED : STATUS_REJECTED;
            if (r.cmd == CMD_LIMIT && left > 0)
            begin
                f = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (!bk_valid[i] && f < 0)
                        f = i;
                if (f >= 0)
                begin
                    bk_valid[f] = 1'b1;
                    bk_side[f] = r.side;
                    bk_price[f] = r.price;
                    bk_ident[f] = r.ident;
                    bk_amount[f] = left;
                    bk_arrival[f] = arrivals;
                    arrivals++;
                    if (!matched)
                        res.status = STATUS_ACCEPTED;
                end
                else
                    res.dropped = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            return 0;
        if (k < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // advance to the next request once the current one is taken
    always @(negedge clk)
    begin
        order_req_t r;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (hold_sender)
            begin
                in_valid <= 1'b0;
                if (!in_valid && awaited_q.size() == 0)
                    hold_sender <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                r = pending_q.pop_front();
                cmd <= r.cmd;
                side <= r.side;
                order_ident <= r.ident;
                limit_price <= r.price;
                amount <= r.amount;
                in_valid <= 1'b1;
                gap_left <= ($urandom_range(0, 9) < 3) ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            sent <= sent + 1;
            await_report(match_order({cmd, side, order_ident, limit_price, amount}));
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            bk_valid[i] = 1'b0;
        arrivals = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left <= pick_gap();
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        fill_report_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            reports_seen <= reports_seen + 1;
            if (awaited_q.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected report ident=%h", echo_ident);
                errors <= errors + 1;
            end
            else
            begin
                exp_r = awaited_q.pop_front();
                if (exp_r.status == STATUS_FILLED)
                    fills_seen <= fills_seen + 1;
                if (exp_r.dropped)
                    drops_seen <= drops_seen + 1;
                if (echo_ident !== exp_r.ident || status !== exp_r.status
                    || first_fill_price !== exp_r.price
                    || filled_amount !== exp_r.filled || rest_dropped !== exp_r.dropped)
                begin
                    if (errors < 10)
                        $display("mismatch exp %h/%0d/%0d/%0d/%0b got %h/%0d/%0d/%0d/%0b",
                                 exp_r.ident, exp_r.status, exp_r.price, exp_r.filled,
                                 exp_r.dropped, echo_ident, status, first_fill_price,
                                 filled_amount, rest_dropped);
                    errors <= errors + 1;
                end
            end
        end
    end

    function automatic order_req_t make_req(logic [1:0] c, logic s, logic [31:0] id,
                                            logic [15:0] p, logic [23:0] a);
        order_req_t r;
        r.cmd = c;
        r.side = s;
        r.ident = id;
        r.price = p;
        r.amount = a;
        return r;
    endfunction

    initial
    begin
        int k;
        logic [1:0] c;
        // directed: rest, sweep, extremes, cancel, bad code, zero size
        queue_req(make_req(CMD_LIMIT, SIDE_SELL, 32'h1, 16'd100, 24'd10));
        queue_req(make_req(CMD_LIMIT, SIDE_SELL, 32'h2, 16'd100, 24'd5));
        queue_req(make_req(CMD_LIMIT, SIDE_SELL, 32'h3, 16'd90, 24'd7));
        queue_req(make_req(CMD_LIMIT, SIDE_BUY, 32'h4, 16'd100, 24'd12));
        queue_req(make_req(CMD_MARKET, SIDE_BUY, 32'h5, 16'd0, 24'd100));
        queue_req(make_req(CMD_LIMIT, SIDE_BUY, 32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF));
        queue_req(make_req(CMD_MARKET, SIDE_SELL, 32'h6, 16'hFFFF, 24'd3));
        queue_req(make_req(CMD_CANCEL, SIDE_SELL, 32'hFFFFFFFF, 16'h0, 24'h0));
        queue_req(make_req(CMD_CANCEL, SIDE_BUY, 32'h12345, 16'h0, 24'h1));
        queue_req(make_req(CMD_BAD, SIDE_BUY, 32'h7, 16'd50, 24'd5));
        queue_req(make_req(CMD_LIMIT, SIDE_BUY, 32'h8, 16'd50, 24'd0));
        queue_req(make_req(CMD_LIMIT, SIDE_BUY, 32'h9, 16'd0, 24'd1));
        queue_req(make_req(CMD_LIMIT, SIDE_SELL, 32'hA, 16'd0, 24'd2));
        queue_req(make_req(CMD_MARKET, SIDE_SELL, 32'hB, 16'd0, 24'd0));
        // fill the book for the full-book case
        for (int i = 0; i < 258; i++)
            queue_req(make_req(CMD_LIMIT, SIDE_SELL, 32'h1000 + i,
                               16'd60000 + i[7:0], 24'd1 + i[3:0]));
        for (int i = 0; i < 260; i++)
            queue_req(make_req(CMD_CANCEL, SIDE_BUY, 32'h1000 + i, 16'd0, 24'd0));
        queue_req(make_req(CMD_MARKET, SIDE_BUY, 32'hC, 16'd0, 24'hFFFFFF));
        queue_req(make_req(CMD_MARKET, SIDE_SELL, 32'hD, 16'd0, 24'hFFFFFF));
        while (pending_q.size() > 0)
            @(posedge clk);
        hold_sender = 1'b1;
        while (hold_sender)
            @(posedge clk);
        for (int n = 0; n < 370; n++)
        begin
            k = $urandom_range(0, 99);
            c = k < 60 ? CMD_LIMIT : k < 80 ? CMD_MARKET : k < 95 ? CMD_CANCEL : CMD_BAD;
            queue_req(make_req(c, 1'($urandom_range(0, 1)),
                32'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 63)),
                16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : 1000 + $urandom_range(0, 40)),
                24'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 16777215)
                                                 : $urandom_range(0, 50))));
            if (n == 185)
            begin
                while (pending_q.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (hold_sender)
                    @(posedge clk);
            end
        end
        while (pending_q.size() > 0 || in_valid || awaited_q.size() > 0)
            @(posedge clk);
        repeat (DEPTH * 4) @(posedge clk);
        $display("Ran %0d orders with %0d reports, %0d with fills and %0d dropped rests,",
                 sent, reports_seen, fills_seen, drops_seen);
        $display("covering sweeps, cancels, bad codes, zero sizes and a full book.");
        if (errors == 0 && awaited_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d reports outstanding", awaited_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
